/* hw/rtl/dd137_pkg.sv */
// Shared types and codes for the 13/7 forward row lifting block.
package dd137_pkg;

  typedef enum logic [1:0] {
    EDGE_CLAMP    = 2'd0,
    EDGE_MIRROR   = 2'd1,
    EDGE_PERIODIC = 2'd2,
    EDGE_ZERO     = 2'd3
  } edge_mode_e;

  typedef enum logic [1:0] {
    REG_EDGE_MODE  = 2'd0,
    REG_QUANT_STEP = 2'd1,
    REG_HALF_WIDTH = 2'd2,
    REG_LAST_ODD   = 2'd3
  } reg_index_e;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_FETCH = 1'b1
  } item_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRD,
    ST_TSUM,
    ST_TWR,
    ST_FCAP,
    ST_FDIV,
    ST_FOUT
  } core_state_e;

  typedef struct packed {
    edge_mode_e  edge_mode;
    logic [14:0] quant_step;
    logic [10:0] half_width;
    logic        last_odd_missing;
  } cfg_t;

  typedef struct packed {
    logic [15:0] low_coef;
    logic [15:0] high_coef;
    logic [9:0]  column;
    logic        row_end;
  } result_t;

  localparam int unsigned NumOperands = 5;
  localparam int unsigned DivSteps    = 16;

endpackage

/* hw/rtl/dd137_div.sv */
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating.
module dd137_div import dd137_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dividend_i,
  input  logic [14:0] divisor_i,
  output logic        done_o,
  output logic [15:0] quotient_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic        neg_q, neg_d;
  logic [15:0] mag_q, mag_d;
  logic [15:0] rem_q, rem_d;
  logic [14:0] div_q, div_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [15:0] shifted;
  logic        fits;

  // Shift in one dividend bit and try the subtraction
  assign shifted = {rem_q[14:0], mag_q[15]};
  assign fits    = shifted >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      neg_d  = dividend_i[15];
      mag_d  = dividend_i[15] ? 16'(-dividend_i) : dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = 5'(DivSteps);
    end else if (busy_q) begin
      rem_d = fits ? 16'(shifted - {1'b0, div_q}) : shifted;
      mag_d = {mag_q[14:0], fits};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    mag_q <= mag_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? 16'(-mag_q) : mag_q;

endmodule

/* hw/rtl/dd137_core.sv */
// Sample, highpass and lowpass stores with the lifting sequencer and fetch path.
module dd137_core import dd137_pkg::*; #(
  parameter int unsigned MAX_HALF_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  input  logic        mode_i,
  input  logic [15:0] even_sample_i,
  input  logic [15:0] odd_sample_i,
  output logic        in_stall_o,
  input  logic        slot_free_i,
  output logic        res_valid_o,
  output result_t     res_o
);

  localparam int unsigned AW   = $clog2(MAX_HALF_WIDTH);
  localparam int unsigned CW   = $clog2(MAX_HALF_WIDTH + 1);
  localparam int unsigned CmpW = (CW > 11) ? CW : 11;

  typedef enum logic [1:0] {
    SRC_EVEN,
    SRC_ODD,
    SRC_HIGH
  } src_e;

  logic [15:0] even_mem [MAX_HALF_WIDTH];
  logic [15:0] odd_mem  [MAX_HALF_WIDTH];
  logic [15:0] high_mem [MAX_HALF_WIDTH];
  logic [15:0] low_mem  [MAX_HALF_WIDTH];
  logic [15:0] even_rd_q, odd_rd_q, high_rd_q, low_rd_q;

  core_state_e state_q, state_d;
  logic [AW-1:0] lc_q, lc_d;
  logic [AW-1:0] fc_q, fc_d;
  logic          ready_q, ready_d;
  logic [AW-1:0] c_q, c_d;
  logic          pass_q, pass_d;
  logic [2:0]    rc_q, rc_d;
  src_e          src_q;
  logic          zero_q;
  logic signed [15:0] op_q [NumOperands];
  logic signed [21:0] t_q;
  logic [15:0]   low_q;
  logic [15:0]   hq_q;

  logic [CmpW-1:0] hw_ext;
  logic [CW-1:0]   eff_w;
  logic [AW-1:0]   wm1, wm2;
  logic            accept, is_fetch;
  logic [CW-1:0]   lc_next, fc_next;
  logic            trigger, last_col, fetch_last, col_end;

  logic [AW-1:0] rd_addr;
  src_e          rd_src;
  logic          rd_zero;
  logic          even_we, odd_we, high_we, low_we;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_even, wr_odd, wr_val;

  logic [AW-1:0] l1_a, p1_a, p2_a, l2_a;
  logic          l1_z, p1_z, p2_z, l2_z;
  logic          div_start, div_done;
  logic [15:0]   div_q;
  logic [14:0]   q_step;
  logic signed [15:0] cap_val;
  logic signed [16:0] s9, sa;
  logic signed [21:0] s9x, sax, t_d;
  logic signed [21:0] tq_adj;
  logic signed [15:0] lift;

  // Clamp the row width into the supported range
  assign hw_ext = CmpW'(cfg_i.half_width);
  always_comb begin
    if (hw_ext < CmpW'(3)) eff_w = CW'(3);
    else if (hw_ext > CmpW'(MAX_HALF_WIDTH)) eff_w = CW'(MAX_HALF_WIDTH);
    else eff_w = CW'(hw_ext);
  end
  assign wm1 = AW'(eff_w - CW'(1));
  assign wm2 = AW'(eff_w - CW'(2));

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign is_fetch   = (mode_i == MODE_FETCH);
  assign lc_next    = CW'(lc_q) + CW'(1);
  assign trigger    = lc_next >= eff_w;
  assign fc_next    = CW'(fc_q) + CW'(1);
  assign fetch_last = fc_next >= eff_w;
  assign last_col   = (c_q == wm1);
  assign col_end    = (state_q == ST_TWR) && last_col;

  // Edge-extended neighbor addresses for the current column
  always_comb begin
    if (c_q != '0) begin
      l1_a = c_q - AW'(1); l1_z = 1'b0;
    end else begin
      unique case (cfg_i.edge_mode) inside
        EDGE_CLAMP, EDGE_MIRROR: begin l1_a = c_q; l1_z = 1'b0; end
        EDGE_PERIODIC:           begin l1_a = wm1; l1_z = 1'b0; end
        default:                 begin l1_a = '0;  l1_z = 1'b1; end
      endcase
    end
    if (c_q < wm1) begin
      p1_a = c_q + AW'(1); p1_z = 1'b0;
    end else begin
      unique case (cfg_i.edge_mode) inside
        EDGE_CLAMP, EDGE_MIRROR: begin p1_a = c_q; p1_z = 1'b0; end
        EDGE_PERIODIC:           begin p1_a = '0;  p1_z = 1'b0; end
        default:                 begin p1_a = '0;  p1_z = 1'b1; end
      endcase
    end
    if (c_q < wm2) begin
      p2_a = c_q + AW'(2); p2_z = 1'b0;
    end else begin
      unique case (cfg_i.edge_mode)
        EDGE_CLAMP:    begin p2_a = p1_a; p2_z = p1_z; end
        EDGE_MIRROR:   begin p2_a = l1_a; p2_z = l1_z; end
        EDGE_PERIODIC: begin p2_a = (c_q == wm2) ? AW'(0) : AW'(1); p2_z = 1'b0; end
        default:       begin p2_a = '0; p2_z = 1'b1; end
      endcase
    end
    if (c_q > AW'(1)) begin
      l2_a = c_q - AW'(2); l2_z = 1'b0;
    end else begin
      unique case (cfg_i.edge_mode)
        EDGE_CLAMP:    begin l2_a = l1_a; l2_z = l1_z; end
        EDGE_MIRROR:   begin l2_a = p1_a; l2_z = p1_z; end
        EDGE_PERIODIC: begin l2_a = wm2 + c_q; l2_z = 1'b0; end
        default:       begin l2_a = '0; l2_z = 1'b1; end
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && ready_q && is_fetch) state_d = ST_FCAP;
        else if (accept && !ready_q && !is_fetch && trigger) state_d = ST_TRD;
      end
      ST_TRD:  if (rc_q == 3'(NumOperands)) state_d = ST_TSUM;
      ST_TSUM: state_d = ST_TWR;
      ST_TWR:  state_d = (last_col && pass_q) ? ST_IDLE : ST_TRD;
      ST_FCAP: state_d = ST_FDIV;
      ST_FDIV: if (div_done) state_d = ST_FOUT;
      ST_FOUT: if (slot_free_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory and unit controls
  always_comb begin
    rd_addr   = c_q;
    rd_src    = SRC_EVEN;
    rd_zero   = 1'b0;
    even_we   = 1'b0;
    odd_we    = 1'b0;
    high_we   = 1'b0;
    low_we    = 1'b0;
    wr_addr   = c_q;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        rd_addr = fc_q;
        wr_addr = lc_q;
        if (accept && !ready_q && !is_fetch) begin
          even_we = 1'b1;
          odd_we  = 1'b1;
        end
      end
      ST_TRD: begin
        case (rc_q)
          3'd0: begin
            rd_addr = pass_q ? c_q : l1_a;
            rd_zero = pass_q ? 1'b0 : l1_z;
            rd_src  = pass_q ? SRC_HIGH : SRC_EVEN;
          end
          3'd1: begin
            rd_addr = pass_q ? p1_a : c_q;
            rd_zero = pass_q ? p1_z : 1'b0;
            rd_src  = pass_q ? SRC_HIGH : SRC_EVEN;
          end
          3'd2: begin
            rd_addr = pass_q ? l1_a : p1_a;
            rd_zero = pass_q ? l1_z : p1_z;
            rd_src  = pass_q ? SRC_HIGH : SRC_EVEN;
          end
          3'd3: begin
            rd_addr = pass_q ? l2_a : p2_a;
            rd_zero = pass_q ? l2_z : p2_z;
            rd_src  = pass_q ? SRC_HIGH : SRC_EVEN;
          end
          default: begin
            rd_addr = c_q;
            rd_src  = (pass_q || (last_col && cfg_i.last_odd_missing)) ? SRC_EVEN : SRC_ODD;
          end
        endcase
      end
      ST_TWR: begin
        high_we = !pass_q;
        low_we  = pass_q;
      end
      ST_FCAP: div_start = 1'b1;
      default: ;
    endcase
  end

  assign wr_even = even_sample_i;
  assign wr_odd  = odd_sample_i;

  // Sample stores
  always_ff @(posedge clk_i) begin
    if (even_we) even_mem[wr_addr] <= wr_even;
    even_rd_q <= even_mem[rd_addr];
  end
  always_ff @(posedge clk_i) begin
    if (odd_we) odd_mem[wr_addr] <= wr_odd;
    odd_rd_q <= odd_mem[rd_addr];
  end

  // Coefficient stores
  always_ff @(posedge clk_i) begin
    if (high_we) high_mem[wr_addr] <= wr_val;
    high_rd_q <= high_mem[rd_addr];
  end
  always_ff @(posedge clk_i) begin
    if (low_we) low_mem[wr_addr] <= wr_val;
    low_rd_q <= low_mem[rd_addr];
  end

  // Pick the operand that arrived from the store read last cycle
  always_comb begin
    if (zero_q) cap_val = '0;
    else begin
      case (src_q)
        SRC_ODD:  cap_val = odd_rd_q;
        SRC_HIGH: cap_val = high_rd_q;
        default:  cap_val = even_rd_q;
      endcase
    end
  end

  // Lifting sums: predict in pass 0, update in pass 1
  assign s9  = pass_q ? (17'(op_q[0]) + 17'(op_q[2])) : (17'(op_q[1]) + 17'(op_q[2]));
  assign sa  = pass_q ? -(17'(op_q[1]) + 17'(op_q[3])) : (17'(op_q[0]) + 17'(op_q[3]));
  assign s9x = 22'(s9);
  assign sax = 22'(sa);
  assign t_d = pass_q ? (sax + (s9x <<< 3) + s9x) : (sax - ((s9x <<< 3) + s9x));

  // Truncating shift by 16 or 32, then add the center sample
  assign tq_adj = t_q + (t_q[21] ? (pass_q ? 22'sd31 : 22'sd15) : 22'sd0);
  assign lift   = pass_q ? 16'(tq_adj >>> 5) : 16'(tq_adj >>> 4);
  assign wr_val = 16'(op_q[4] + lift);

  assign q_step = (cfg_i.quant_step == '0) ? 15'd1 : cfg_i.quant_step;

  dd137_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (high_rd_q),
    .divisor_i  (q_step),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // Control counters
  always_comb begin
    lc_d    = lc_q;
    fc_d    = fc_q;
    ready_d = ready_q;
    c_d     = c_q;
    pass_d  = pass_q;
    rc_d    = rc_q;
    if (accept && !ready_q && !is_fetch) begin
      lc_d = AW'(lc_next);
      if (trigger) begin
        ready_d = 1'b0;
        c_d     = '0;
        pass_d  = 1'b0;
        rc_d    = '0;
      end
    end
    if (state_q == ST_TRD) rc_d = rc_q + 3'd1;
    if (state_q == ST_TWR) begin
      rc_d = '0;
      c_d  = last_col ? '0 : c_q + AW'(1);
      if (col_end) begin
        pass_d = 1'b1;
        if (pass_q) begin
          ready_d = 1'b1;
          fc_d    = '0;
        end
      end
    end
    if (state_q == ST_FOUT && slot_free_i) begin
      if (fetch_last) begin
        ready_d = 1'b0;
        lc_d    = '0;
        fc_d    = '0;
      end else begin
        fc_d = AW'(fc_next);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lc_q    <= '0;
      fc_q    <= '0;
      ready_q <= 1'b0;
      c_q     <= '0;
      pass_q  <= 1'b0;
      rc_q    <= '0;
    end else begin
      state_q <= state_d;
      lc_q    <= lc_d;
      fc_q    <= fc_d;
      ready_q <= ready_d;
      c_q     <= c_d;
      pass_q  <= pass_d;
      rc_q    <= rc_d;
    end
  end

  // Operand and fetch datapath
  always_ff @(posedge clk_i) begin
    src_q  <= rd_src;
    zero_q <= rd_zero;
    if (state_q == ST_TRD && rc_q != '0) op_q[rc_q - 3'd1] <= cap_val;
    if (state_q == ST_TSUM) t_q <= t_d;
    if (state_q == ST_FCAP) low_q <= low_rd_q;
    if (state_q == ST_FDIV && div_done) hq_q <= div_q;
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign res_valid_o       = (state_q == ST_FOUT) && slot_free_i;
  assign res_o.low_coef    = low_q;
  assign res_o.high_coef   = hq_q;
  assign res_o.column      = 10'(fc_q);
  assign res_o.row_end     = fetch_last;

  // Checks
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o) else $error("busy core not stalling");
  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_FDIV)) else $error("divider done outside wait");
  a_res_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> slot_free_i) else $error("result issued into full slot");
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TWR) |-> (CW'(c_q) < eff_w)) else $error("column past row width");
  a_ready_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FCAP) |-> ready_q) else $error("fetch without ready row");

endmodule

/* hw/rtl/dd137_forward_lift_row_unit.sv */
// Top level of the 13/7 forward row lifting block: registers, core and output slot.
//
// Usage: configure edge_mode, quant_step, half_width and last_odd_missing over
// the cfg channel (cfg_ready_o is always high) while the block is idle.
// Input items with mode 0 load one (even, odd) sample pair; after half_width
// pairs the row is lifted into the coefficient stores. Items with mode 1 then
// fetch one lowpass and quantized highpass pair each, in column order, with
// row_end on the last. Loads during a ready row and fetches before one are
// dropped without result. The row pass reads five operands per column from
// the single-port-read stores in two passes over the row, during which
// in_stall_o stays high. A fetch runs the 16-step bit-serial quantizing divider.
// The output register holds a result while out_stall_i is high; the block
// keeps accepting loads, and a fetch waits for the slot to free.
// Reset clears the counters and row status; store contents are left as is,
// so no clearing pass is run and the block is ready right after reset.
module dd137_forward_lift_row_unit import dd137_pkg::*; #(
  parameter int unsigned MAX_HALF_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [15:0] even_sample_i,
  input  logic [15:0] odd_sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] low_coef_o,
  output logic [15:0] high_coef_o,
  output logic [9:0]  column_o,
  output logic        row_end_o
);

  cfg_t    cfg_q, cfg_d;
  logic    out_valid_q, out_valid_d;
  result_t out_q;
  result_t res;
  logic    res_valid;
  logic    slot_free;

  // Register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (reg_index_e'(cfg_index_i))
        REG_EDGE_MODE:  cfg_d.edge_mode        = edge_mode_e'(cfg_data_i[1:0]);
        REG_QUANT_STEP: cfg_d.quant_step       = cfg_data_i;
        REG_HALF_WIDTH: cfg_d.half_width       = cfg_data_i[10:0];
        REG_LAST_ODD:   cfg_d.last_odd_missing = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.edge_mode        <= EDGE_CLAMP;
      cfg_q.quant_step       <= 15'd1;
      cfg_q.half_width       <= 11'd1024;
      cfg_q.last_odd_missing <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  dd137_core #(
    .MAX_HALF_WIDTH (MAX_HALF_WIDTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .mode_i        (mode_i),
    .even_sample_i (even_sample_i),
    .odd_sample_i  (odd_sample_i),
    .in_stall_o    (in_stall_o),
    .slot_free_i   (slot_free),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // Output slot: hold while stalled, load when free
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign low_coef_o  = out_q.low_coef;
  assign high_coef_o = out_q.high_coef;
  assign column_o    = out_q.column;
  assign row_end_o   = out_q.row_end;

  // Checks
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !(out_valid_q && out_stall_i)) else $error("slot overwritten");
  a_load_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> out_valid_q) else $error("result lost");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> !in_stall_o)
    else $error("register write while core busy");

endmodule
